// ===== rtl/bskl_pkg.sv =====
package bskl_pkg;

   // fixed field widths of the channel payloads
   localparam int KEY_FIELD_BITS   = 64;
   localparam int COUNT_FIELD_BITS = 4;
   localparam int OP_FIELD_BITS    = 2;

   // operation codes
   localparam logic [OP_FIELD_BITS-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_FIELD_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_FIELD_BITS-1:0] OP_TAKE   = 2'd2;

   // request transaction
   typedef struct packed {
      logic [OP_FIELD_BITS-1:0]  operation;
      logic [KEY_FIELD_BITS-1:0] key;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [KEY_FIELD_BITS-1:0]   taken_key;
      logic                        found;
      logic                        kept;
      logic [COUNT_FIELD_BITS-1:0] entry_count;
   } rsp_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic live;      // read data holds an entry this cycle
      logic first;     // entry is the first of the pass
      logic find_max;  // search for largest, else smallest
   } scan_ctl_type;

endpackage

// ===== rtl/bskl_scan.sv =====
module bskl_scan import bskl_pkg::*; #(
   parameter int KEY_BITS = 64,
   parameter int IDX_W    = 4
) (
   input  logic                clock,
   input  scan_ctl_type        ctl,
   input  logic [KEY_BITS-1:0] entry_key,
   input  logic [IDX_W-1:0]    entry_idx,
   output logic [KEY_BITS-1:0] best_key,
   output logic [IDX_W-1:0]    best_idx
);

   logic [KEY_BITS-1:0] best_key_ff;
   logic [KEY_BITS-1:0] best_key_in;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [IDX_W-1:0]    best_idx_in;
   logic                better;

   // strict compare so ties keep the lowest slot
   always_comb begin
      better = ctl.find_max ? (entry_key > best_key_ff) : (entry_key < best_key_ff);
      best_key_in = best_key_ff;
      best_idx_in = best_idx_ff;
      if (ctl.live && (ctl.first || better)) begin
         best_key_in = entry_key;
         best_idx_in = entry_idx;
      end
   end

   // running best, payload only
   always_ff @(posedge clock) begin
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
   end

   assign best_key = best_key_ff;
   assign best_idx = best_idx_ff;

endmodule

// ===== rtl/bounded_smallest_key_list_unit.sv =====
// Keeps up to LIST_DEPTH of the smallest keys inserted since the last clear, in an
// unsorted table with one write port and one registered read port, and returns one
// response per request. Clear, an insert with room left, a take on an empty table and
// an unused code go from dispatch straight to the done state, which raises rsp_valid.
// An insert into a full table and a take first scan the held entries: the table has
// one registered read port, so the compare unit walks the held entries one per clock
// to find the largest or smallest. One request is in work at a time; req_ready is
// high only while the sequencer is idle, and it comes back in the cycle the response
// appears, so a new request is accepted only once the last response is raised. A
// finished response waits in the output register until rsp_ready, and the next
// response cannot be raised until it is taken. Keys keep their low KEY_BITS bits.
module bounded_smallest_key_list_unit import bskl_pkg::*; #(
   parameter int LIST_DEPTH = 10,
   parameter int KEY_BITS   = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_SCAN     = 6'b000100,
      ST_DECIDE   = 6'b001000,
      ST_MOVE     = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [OP_FIELD_BITS-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [CNT_W-1:0]         held_ff, held_in;
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic                     rd_live_ff, rd_live_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [KEY_BITS-1:0]      taken_ff, taken_in;
   logic                     found_ff, found_in;
   logic                     kept_ff, kept_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // table storage, reset leaves it undefined
   logic [KEY_BITS-1:0] entry_mem_ff [LIST_DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [KEY_BITS-1:0] wr_data;

   logic [CNT_W-1:0]    last_cnt;
   logic [IDX_W-1:0]    last_idx;
   logic                out_free;
   scan_ctl_type        scan_ctl;
   logic [KEY_BITS-1:0] best_key;
   logic [IDX_W-1:0]    best_idx;

   assign last_cnt = held_ff - CNT_W'(1);
   assign last_idx = last_cnt[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // shared compare unit for both max and min passes
   assign scan_ctl.live     = rd_live_ff && (state_ff == ST_SCAN);
   assign scan_ctl.first    = (rd_idx_ff == '0);
   assign scan_ctl.find_max = (op_ff == OP_INSERT);

   bskl_scan #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
   ) u_scan (
      .clock     (clock),
      .ctl       (scan_ctl),
      .entry_key (rd_data_ff),
      .entry_idx (rd_idx_ff),
      .best_key  (best_key),
      .best_idx  (best_idx)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      held_in      = held_ff;
      issue_in     = issue_ff;
      rd_live_in   = 1'b0;
      rd_idx_in    = issue_ff[IDX_W-1:0];
      taken_in     = taken_ff;
      found_in     = found_ff;
      kept_in      = kept_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = issue_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = best_idx;
      wr_data      = key_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_data.operation;
               key_in   = req_data.key[KEY_BITS-1:0];
               taken_in = '0;
               found_in = 1'b0;
               kept_in  = 1'b0;
               issue_in = '0;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_CLEAR: begin
                  held_in = '0;
               end
               OP_INSERT: begin
                  if (held_ff < CNT_W'(LIST_DEPTH)) begin
                     wr_en   = 1'b1;
                     wr_addr = held_ff[IDX_W-1:0];
                     held_in = held_ff + CNT_W'(1);
                     kept_in = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               OP_TAKE: begin
                  if (held_ff != '0) begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // one read issued and one entry compared per cycle
         ST_SCAN: begin
            if (issue_ff < held_ff) begin
               rd_live_in = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
            end
            if (rd_live_ff && (rd_idx_ff == last_idx)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (op_ff == OP_INSERT) begin
               if (best_key > key_ff) begin
                  wr_en   = 1'b1;
                  kept_in = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               // fetch the last entry to fill the freed slot
               rd_addr  = last_idx;
               taken_in = best_key;
               found_in = 1'b1;
               held_in  = last_cnt;
               state_in = ST_MOVE;
            end
         end

         ST_MOVE: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.taken_key   = KEY_FIELD_BITS'(taken_ff);
               rsp_data_in.found       = found_ff;
               rsp_data_in.kept        = kept_ff;
               rsp_data_in.entry_count = COUNT_FIELD_BITS'(held_ff);
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      taken_ff    <= taken_in;
      found_ff    <= found_in;
      kept_ff     <= kept_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
